@@ hdl/qpc_pkg.sv @@
// shared types, field layout and the gray transition table of the quadrature counter
package qpc_pkg;

  // fixed field widths
  localparam int MOD_W   = 31;
  localparam int PHASE_W = 2;
  localparam int NV_W    = 32;
  localparam int OUT_W   = 32;
  localparam int OP_W    = 2;

  // input transaction layout (tdata)
  localparam int IN_PH_LSB   = 0;
  localparam int IN_IDX_BIT  = 2;
  localparam int IN_NV_LSB   = 3;
  localparam int IN_TDATA_W  = 40;

  // result transaction layout (tdata)
  localparam int OUT_POS_LSB  = 0;
  localparam int OUT_IDX_LSB  = 32;
  localparam int OUT_ARM_BIT  = 64;
  localparam int OUT_ERR_BIT  = 65;
  localparam int OUT_TDATA_W  = 72;
  localparam int OUT_PAD_W    = OUT_TDATA_W - 2 * OUT_W - 2;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_SET    = 2'd1,
    OP_ARM    = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STEP_HOLD = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  // previous phase in the upper two bits, current phase in the lower two
  function automatic step_t gray_step(input logic [2*PHASE_W-1:0] idx);
    step_t s;
    unique case (idx)
      4'd0:  s = STEP_HOLD;
      4'd1:  s = STEP_DOWN;
      4'd2:  s = STEP_UP;
      4'd3:  s = STEP_HOLD;
      4'd4:  s = STEP_UP;
      4'd5:  s = STEP_HOLD;
      4'd6:  s = STEP_HOLD;
      4'd7:  s = STEP_DOWN;
      4'd8:  s = STEP_DOWN;
      4'd9:  s = STEP_HOLD;
      4'd10: s = STEP_HOLD;
      4'd11: s = STEP_UP;
      4'd12: s = STEP_HOLD;
      4'd13: s = STEP_UP;
      4'd14: s = STEP_DOWN;
      4'd15: s = STEP_HOLD;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/qpc_remainder.sv @@
// bit-serial true modulo of a signed position by the modulus register
module qpc_remainder #(
  parameter int POS_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [POS_WIDTH-1:0]        operand,
  input  logic [qpc_pkg::MOD_W-1:0]   modulus,
  output logic                        done,
  output logic [POS_WIDTH-1:0]        result
);

  localparam int MW    = qpc_pkg::MOD_W;
  localparam int CNT_W = $clog2(POS_WIDTH + 1);

  logic                 busy_r;
  logic                 done_r;
  logic                 neg_r;
  logic [POS_WIDTH-1:0] mag_r;
  logic [MW-1:0]        rem_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [POS_WIDTH-1:0] result_r;

  logic [MW:0]          rem_sh;
  logic [MW:0]          rem_sub;
  logic [MW-1:0]        rem_step;
  logic [MW-1:0]        rem_fix;

  // one restoring step: shift in the next magnitude bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem_r, mag_r[POS_WIDTH-1]};
    rem_sub  = rem_sh - {1'b0, modulus};
    rem_step = (rem_sh >= {1'b0, modulus}) ? rem_sub[MW-1:0] : rem_sh[MW-1:0];
    // negative operand folds back into the non-negative range
    rem_fix  = (neg_r && (rem_r != '0)) ? (modulus - rem_r) : rem_r;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(POS_WIDTH);
    end else if (busy_r && (cnt_r == '0)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= operand[POS_WIDTH-1];
      mag_r <= operand[POS_WIDTH-1] ? (~operand + 1'b1) : operand;
      rem_r <= '0;
    end else if (busy_r && (cnt_r != '0)) begin
      mag_r <= {mag_r[POS_WIDTH-2:0], 1'b0};
      rem_r <= rem_step;
    end
    if (busy_r && (cnt_r == '0)) begin
      result_r <= POS_WIDTH'(rem_fix);
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

@@ hdl/qpc_step.sv @@
// combinational work for one transaction: reduce, count step, index handling, set and arm
module qpc_step #(
  parameter int POS_WIDTH = 32
) (
  input  logic [qpc_pkg::MOD_W-1:0]    modulus,
  input  logic                         skip_fix,
  input  qpc_pkg::opcode_t             opcode,
  input  logic [qpc_pkg::PHASE_W-1:0]  phase_bits,
  input  logic                         index_mark,
  input  logic signed [qpc_pkg::NV_W-1:0] new_value,
  input  logic [POS_WIDTH-1:0]         count,
  input  logic [qpc_pkg::PHASE_W-1:0]  last_phase,
  input  logic [POS_WIDTH-1:0]         capture,
  input  logic                         armed,
  output logic [POS_WIDTH-1:0]         count_nxt,
  output logic [qpc_pkg::PHASE_W-1:0]  phase_nxt,
  output logic [POS_WIDTH-1:0]         capture_nxt,
  output logic                         armed_nxt,
  output logic                         range_err
);

  localparam int MW    = qpc_pkg::MOD_W;
  localparam int NW    = qpc_pkg::NV_W;
  localparam int EXT_W = ((POS_WIDTH > MW) ? POS_WIDTH : MW) + 1;

  logic                 mod_on;
  logic                 fix_on;
  logic [EXT_W-1:0]     mod_ext;
  logic [POS_WIDTH-1:0] cnt_red;
  logic [POS_WIDTH-1:0] cap_red;
  logic [EXT_W-1:0]     cnt_red_ext;
  logic [EXT_W-1:0]     inc_ext;
  logic [EXT_W-1:0]     dec_ext;
  logic [POS_WIDTH-1:0] stepped;
  logic [POS_WIDTH-1:0] nv_pos;
  logic                 nv_ok;
  qpc_pkg::step_t       dir;

  // held values stay below the modulus, so a set sign bit means a negative
  // reading that the true modulo lifts by one modulus
  always_comb begin
    mod_on  = (modulus != '0);
    fix_on  = mod_on && !skip_fix;
    mod_ext = EXT_W'(modulus);
    cnt_red = (fix_on && count[POS_WIDTH-1]) ?
              POS_WIDTH'(EXT_W'(count) + mod_ext) : count;
    cap_red = (fix_on && capture[POS_WIDTH-1]) ?
              POS_WIDTH'(EXT_W'(capture) + mod_ext) : capture;
  end

  // count step with optional wrap into the modulus range
  always_comb begin
    dir         = qpc_pkg::gray_step({last_phase, phase_bits});
    cnt_red_ext = EXT_W'(cnt_red);
    inc_ext     = cnt_red_ext + 1'b1;
    if (inc_ext >= mod_ext) begin
      inc_ext = '0;
    end
    dec_ext = (cnt_red == '0) ? (mod_ext - 1'b1) : (cnt_red_ext - 1'b1);
    unique case (dir)
      qpc_pkg::STEP_HOLD: stepped = cnt_red;
      qpc_pkg::STEP_UP:   stepped = mod_on ? POS_WIDTH'(inc_ext) : (cnt_red + 1'b1);
      qpc_pkg::STEP_DOWN: stepped = mod_on ? POS_WIDTH'(dec_ext) : (cnt_red - 1'b1);
      default:            stepped = cnt_red;
    endcase
  end

  // range check of a written value
  always_comb begin
    nv_pos = POS_WIDTH'(new_value);
    nv_ok  = !mod_on || (!new_value[NW-1] && (new_value[NW-2:0] < modulus));
  end

  // per-opcode state update
  always_comb begin
    count_nxt   = cnt_red;
    capture_nxt = cap_red;
    armed_nxt   = armed;
    phase_nxt   = last_phase;
    range_err   = 1'b0;
    unique case (opcode)
      qpc_pkg::OP_SAMPLE: begin
        count_nxt = stepped;
        phase_nxt = phase_bits;
        if (index_mark) begin
          if (armed) begin
            count_nxt = cap_red;
            armed_nxt = 1'b0;
          end else begin
            capture_nxt = stepped;
          end
        end
      end
      qpc_pkg::OP_SET: begin
        if (!nv_ok) begin
          range_err = 1'b1;
        end else begin
          count_nxt = nv_pos;
        end
      end
      qpc_pkg::OP_ARM: begin
        if (!nv_ok) begin
          range_err = 1'b1;
        end else begin
          capture_nxt = nv_pos;
          armed_nxt   = 1'b1;
        end
      end
      qpc_pkg::OP_NOP: begin
        range_err = 1'b0;
      end
      default: begin
        range_err = 1'b0;
      end
    endcase
  end

endmodule

@@ hdl/quadrature_position_counter_core.sv @@
// top level of the quadrature position counter with index mark and modulus wrap
// Each input transaction (a phase sample, a set, an arm of an index preset or a no-op)
// yields exactly one result transaction; in steady state one is taken every clock while
// the result side does not stall, limited by the combinational add, compare and wrap on
// the position; the result register is loaded on acceptance. After a write to the
// modulus register the held position and index capture must be brought into the new
// range: if the modulus is nonzero, the first transaction waits while a bit-serial
// remainder unit works through both values; a further modulus write during that time
// restarts it. With a zero modulus the first transaction waits until the dirty flag clears.
module quadrature_position_counter_core #(
  parameter int POS_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input: tuser = opcode[1:0]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [qpc_pkg::OP_W-1:0]        in_tuser,
  // input: tdata = phase_bits[1:0], index_mark[2], new_value[34:3], zero pad[39:35]
  input  logic [qpc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result: tdata = position[31:0], index_position[63:32], preset_armed[64],
  // range_error[65], zero pad[71:66]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [qpc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // modulus register write
  input  logic                            cfg_we,
  input  logic [qpc_pkg::MOD_W-1:0]       cfg_wdata
);

  localparam int MW    = qpc_pkg::MOD_W;
  localparam int PW    = qpc_pkg::PHASE_W;
  localparam int NW    = qpc_pkg::NV_W;
  localparam int OW    = qpc_pkg::OUT_W;
  localparam int EXT_W = ((POS_WIDTH > MW) ? POS_WIDTH : MW) + 1;

  typedef enum logic [2:0] {
    ST_RUN     = 3'b001,
    ST_RED_CNT = 3'b010,
    ST_RED_CAP = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic [MW-1:0]                modulus_r;
  logic                         dirty_r, dirty_nxt;
  logic                         skip_r;
  logic [POS_WIDTH-1:0]         count_r;
  logic [POS_WIDTH-1:0]         cap_r;
  logic [PW-1:0]                phase_r;
  logic                         armed_r;
  logic [POS_WIDTH-1:0]         red_cnt_r;
  logic                         out_tvalid_r;
  logic [qpc_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic                         in_acc;
  qpc_pkg::opcode_t             op;
  logic [POS_WIDTH-1:0]         count_nxt;
  logic [PW-1:0]                phase_nxt;
  logic [POS_WIDTH-1:0]         cap_nxt;
  logic                         armed_nxt;
  logic                         range_err;

  logic                         rem_start;
  logic [POS_WIDTH-1:0]         rem_operand;
  logic                         rem_done;
  logic [POS_WIDTH-1:0]         rem_result;

  // handshake
  assign in_tready = (state_r == ST_RUN) && !dirty_r && (!out_tvalid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign op        = qpc_pkg::opcode_t'(in_tuser);

  // per-transaction datapath
  qpc_step #(
    .POS_WIDTH (POS_WIDTH)
  ) u_step (
    .modulus     (modulus_r),
    .skip_fix    (skip_r),
    .opcode      (op),
    .phase_bits  (in_tdata[qpc_pkg::IN_PH_LSB +: PW]),
    .index_mark  (in_tdata[qpc_pkg::IN_IDX_BIT]),
    .new_value   (signed'(in_tdata[qpc_pkg::IN_NV_LSB +: NW])),
    .count       (count_r),
    .last_phase  (phase_r),
    .capture     (cap_r),
    .armed       (armed_r),
    .count_nxt   (count_nxt),
    .phase_nxt   (phase_nxt),
    .capture_nxt (cap_nxt),
    .armed_nxt   (armed_nxt),
    .range_err   (range_err)
  );

  // shared remainder unit for bringing held values into a new modulus range
  qpc_remainder #(
    .POS_WIDTH (POS_WIDTH)
  ) u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rem_start),
    .operand (rem_operand),
    .modulus (modulus_r),
    .done    (rem_done),
    .result  (rem_result)
  );

  // reduction sequencer, a modulus write always wins and restarts it
  always_comb begin
    state_nxt   = state_r;
    dirty_nxt   = dirty_r;
    rem_start   = 1'b0;
    rem_operand = count_r;
    if (cfg_we) begin
      state_nxt = ST_RUN;
      dirty_nxt = 1'b1;
    end else begin
      unique case (state_r)
        ST_RUN: begin
          if (dirty_r) begin
            dirty_nxt = 1'b0;
            if (modulus_r != '0) begin
              rem_start = 1'b1;
              state_nxt = ST_RED_CNT;
            end
          end
        end
        ST_RED_CNT: begin
          if (rem_done) begin
            rem_start   = 1'b1;
            rem_operand = cap_r;
            state_nxt   = ST_RED_CAP;
          end
        end
        ST_RED_CAP: begin
          if (rem_done) begin
            state_nxt = ST_RUN;
          end
        end
        default: begin
          state_nxt = ST_RUN;
        end
      endcase
    end
  end

  // control and held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      dirty_r      <= 1'b0;
      skip_r       <= 1'b0;
      modulus_r    <= '0;
      count_r      <= '0;
      cap_r        <= '0;
      phase_r      <= '0;
      armed_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
      if (cfg_we) begin
        modulus_r <= cfg_wdata;
      end
      // commit both reduced values together
      if (!cfg_we && (state_r == ST_RED_CAP) && rem_done) begin
        count_r <= red_cnt_r;
        cap_r   <= rem_result;
        skip_r  <= 1'b1;
      end else if (in_acc) begin
        count_r <= count_nxt;
        cap_r   <= cap_nxt;
        phase_r <= phase_nxt;
        armed_r <= armed_nxt;
        skip_r  <= 1'b0;
      end
      if (in_acc) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // result register and reduced count holding
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_tdata_r <= {{qpc_pkg::OUT_PAD_W{1'b0}}, range_err, armed_nxt,
                      OW'(cap_nxt), OW'(count_nxt)};
    end
    if ((state_r == ST_RED_CNT) && rem_done) begin
      red_cnt_r <= rem_result;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // held position stays inside the modulus range once a transaction has settled it
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && !dirty_r && !skip_r && (modulus_r != '0))
      |-> (EXT_W'(count_r) < EXT_W'(modulus_r)))
    else $error("position outside modulus range");

  // same for the index capture or armed preset
  a_cap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && !dirty_r && !skip_r && (modulus_r != '0))
      |-> (EXT_W'(cap_r) < EXT_W'(modulus_r)))
    else $error("index capture outside modulus range");

  // a reduced value is used unmodified only by the first transaction
  a_skip_once: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !skip_r)
    else $error("reduction bypass still set after a transaction");

  // a rejected value is only possible with wrapping enabled
  a_err_needs_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[qpc_pkg::OUT_ERR_BIT]) |-> (modulus_r != '0))
    else $error("range error reported with wrapping disabled");

endmodule

@@ tb/qpc_position_check.sv @@
// result checker: predicts every quadrature counter result and compares the result stream
module qpc_position_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [qpc_pkg::OP_W-1:0]        in_tuser,
  input  logic [qpc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [qpc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [qpc_pkg::MOD_W-1:0]       cfg_wdata,
  output int                              mismatches,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [qpc_pkg::OUT_W-1:0] position;
    logic [qpc_pkg::OUT_W-1:0] index_position;
    logic                      preset_armed;
    logic                      range_error;
  } reading_t;

  // shadow copy of the counter state
  logic [qpc_pkg::MOD_W-1:0]   modulus;
  logic [qpc_pkg::OUT_W-1:0]   count;
  logic [qpc_pkg::PHASE_W-1:0] last_phase;
  logic [qpc_pkg::OUT_W-1:0]   index_capture;
  logic                        armed;

  reading_t expected_readings[$];
  int       fail_cnt = 0;

  // true modulo into [0, modulus) when wrapping is enabled
  function automatic logic [qpc_pkg::OUT_W-1:0] fold_into_range(
    input logic [qpc_pkg::OUT_W-1:0] v);
    longint sv;
    longint m;
    longint r;
    if (modulus == '0) return v;
    sv = longint'($signed(v));
    m  = longint'(modulus);
    r  = sv % m;
    if (r < 0) r += m;
    return r[qpc_pkg::OUT_W-1:0];
  endfunction

  // direction of one phase change, forward order is 00 -> 10 -> 11 -> 01
  function automatic int quadrature_step(input logic [1:0] from, input logic [1:0] to);
    logic [1:0] p_from;
    logic [1:0] p_to;
    logic [1:0] delta;
    p_from = {from[0], from[1] ^ from[0]};
    p_to   = {to[0], to[1] ^ to[0]};
    delta  = p_to - p_from;
    if (delta == 2'd1) return 1;
    if (delta == 2'd3) return -1;
    return 0;
  endfunction

  // apply one input transaction to the shadow state and return the expected result
  function automatic reading_t advance_position(input qpc_pkg::opcode_t op,
                                                input logic [1:0] ph,
                                                input logic mark,
                                                input logic [qpc_pkg::NV_W-1:0] nv);
    int       d;
    logic     err;
    reading_t res;
    err = 1'b0;
    count         = fold_into_range(count);
    index_capture = fold_into_range(index_capture);
    case (op)
      qpc_pkg::OP_SAMPLE: begin
        d = quadrature_step(last_phase, ph);
        if (modulus != '0) begin
          if (d > 0)
            count = ({1'b0, count} + 1 >= {2'b0, modulus}) ? '0 : count + 1;
          else if (d < 0)
            count = (count == '0) ? {1'b0, modulus} - 1 : count - 1;
        end else begin
          count = count + qpc_pkg::OUT_W'(d);
        end
        last_phase = ph;
        // index mark: load a pending preset, else capture
        if (mark) begin
          if (armed) begin
            count = index_capture;
            armed = 1'b0;
          end else begin
            index_capture = count;
          end
        end
      end
      qpc_pkg::OP_SET, qpc_pkg::OP_ARM: begin
        if (modulus != '0 && (nv[qpc_pkg::NV_W-1] || nv >= {1'b0, modulus}))
          err = 1'b1;
        else if (op == qpc_pkg::OP_SET)
          count = nv;
        else begin
          index_capture = nv;
          armed         = 1'b1;
        end
      end
      default: ;
    endcase
    res.position       = count;
    res.index_position = index_capture;
    res.preset_armed   = armed;
    res.range_error    = err;
    return res;
  endfunction

  // watch both channels and the register port at every rising edge
  always @(posedge clk) begin
    reading_t want;
    reading_t got;
    if (!rst_n) begin
      modulus       = '0;
      count         = '0;
      last_phase    = '0;
      index_capture = '0;
      armed         = 1'b0;
      expected_readings.delete();
    end else begin
      // result transaction against the oldest expectation
      if (out_tvalid && out_tready) begin
        got.position       = out_tdata[qpc_pkg::OUT_POS_LSB +: qpc_pkg::OUT_W];
        got.index_position = out_tdata[qpc_pkg::OUT_IDX_LSB +: qpc_pkg::OUT_W];
        got.preset_armed   = out_tdata[qpc_pkg::OUT_ARM_BIT];
        got.range_error    = out_tdata[qpc_pkg::OUT_ERR_BIT];
        if (expected_readings.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected result pos=%0d idx=%0d armed=%0b err=%0b",
                     $realtime, $signed(got.position), $signed(got.index_position),
                     got.preset_armed, got.range_error);
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display({"%0t: result mismatch expected pos=%0d idx=%0d armed=%0b err=%0b,",
                        " got pos=%0d idx=%0d armed=%0b err=%0b"},
                       $realtime, $signed(want.position), $signed(want.index_position),
                       want.preset_armed, want.range_error, $signed(got.position),
                       $signed(got.index_position), got.preset_armed, got.range_error);
          end
        end
      end
      // input transaction
      if (in_tvalid && in_tready)
        expected_readings.push_back(
          advance_position(qpc_pkg::opcode_t'(in_tuser),
                           in_tdata[qpc_pkg::IN_PH_LSB +: qpc_pkg::PHASE_W],
                           in_tdata[qpc_pkg::IN_IDX_BIT],
                           in_tdata[qpc_pkg::IN_NV_LSB +: qpc_pkg::NV_W]));
      // modulus register write
      if (cfg_we)
        modulus = cfg_wdata;
    end
    mismatches  <= fail_cnt;
    outstanding <= expected_readings.size();
  end

endmodule

@@ tb/quadrature_position_counter_core_test.sv @@
// top of the quadrature counter testbench: clock, reset, stimulus, stalls and verdict
module quadrature_position_counter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 185;
  localparam int NUM_PHASES  = 8;

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [qpc_pkg::OP_W-1:0]        in_tuser   = qpc_pkg::OP_SAMPLE;
  logic [qpc_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [qpc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_we     = 1'b0;
  logic [qpc_pkg::MOD_W-1:0]       cfg_wdata  = '0;

  int         mismatches;
  int         outstanding;
  int         quiet_cycles = 0;
  int         ready_hold   = 0;
  bit         idling_on    = 1'b1;
  logic [1:0] sent_phase   = 2'b00;

  quadrature_position_counter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  qpc_position_check position_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_tready = 1'b0;
    end else if (idling_on && $urandom_range(0, 6) == 0) begin
      ready_hold = $urandom_range(0, 18);
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one transaction, with an optional gap before it, and wait for acceptance
  task automatic drive_item(input qpc_pkg::opcode_t op, input logic [1:0] ph,
                            input logic mark, input logic [qpc_pkg::NV_W-1:0] nv);
    int gap;
    gap = (idling_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser                                         = op;
    in_tdata                                         = '0;
    in_tdata[qpc_pkg::IN_PH_LSB +: qpc_pkg::PHASE_W] = ph;
    in_tdata[qpc_pkg::IN_IDX_BIT]                    = mark;
    in_tdata[qpc_pkg::IN_NV_LSB +: qpc_pkg::NV_W]    = nv;
    in_tvalid                                        = 1'b1;
    if (op == qpc_pkg::OP_SAMPLE) sent_phase = ph;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // drain all results, then write the modulus while the block is idle
  task automatic load_modulus(input logic [qpc_pkg::MOD_W-1:0] m);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_wdata = m;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // set/preset value: mostly in range, with range edges and extremes
  function automatic logic [qpc_pkg::NV_W-1:0] pick_new_value(
    input logic [qpc_pkg::MOD_W-1:0] m);
    logic [qpc_pkg::NV_W-1:0] top_val;
    top_val = (m == '0) ? '1 : {1'b0, m} - 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return (m == '0) ? $urandom : $urandom_range(0, top_val);
      6: return {1'b0, m};
      7: begin
        case ($urandom_range(0, 3))
          0: return top_val;
          1: return '1;
          2: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // mostly legal encoder motion, with holds, double steps, sets, arms and no-op opcodes
  task automatic random_item(input logic [qpc_pkg::MOD_W-1:0] m);
    int unsigned      pick;
    logic [1:0]       ph;
    qpc_pkg::opcode_t op;
    pick = $urandom_range(0, 99);
    ph   = 2'($urandom_range(0, 3));
    if (pick < 72) begin
      op = qpc_pkg::OP_SAMPLE;
      case ($urandom_range(0, 9))
        7: ;
        8: ph = sent_phase;
        9: ph = ~sent_phase;
        default: ph = sent_phase ^ ($urandom_range(0, 1) ? 2'b01 : 2'b10);
      endcase
    end else if (pick < 84) begin
      op = qpc_pkg::OP_SET;
    end else if (pick < 96) begin
      op = qpc_pkg::OP_ARM;
    end else begin
      op = qpc_pkg::OP_NOP;
    end
    drive_item(op, ph, $urandom_range(0, 9) == 0, pick_new_value(m));
  endtask

  // stimulus and verdict
  initial begin
    logic [qpc_pkg::MOD_W-1:0] plan [NUM_PHASES];
    int p;
    int i;
    plan[0] = 31'd5;
    plan[1] = 31'd0;
    plan[2] = 31'd3;
    plan[3] = 31'h7FFF_FFFF;
    plan[4] = 31'd1;
    plan[5] = 31'($urandom_range(2, 64));
    plan[6] = 31'd0;
    plan[7] = 31'($urandom_range(32'h1000_0000, 32'h7FFF_FFFE));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no wrapping: steps both ways, double change, 32-bit wrap, index capture and preset
    drive_item(qpc_pkg::OP_SAMPLE, 2'b00, 1'b0, $urandom);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b10, 1'b0, $urandom);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b11, 1'b0, $urandom);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b01, 1'b0, $urandom);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b00, 1'b0, $urandom);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b01, 1'b0, $urandom);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b10, 1'b0, $urandom);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b10, 1'b1, $urandom);
    drive_item(qpc_pkg::OP_SET,    2'b11, 1'b1, 32'h7FFF_FFFF);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b11, 1'b0, $urandom);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b10, 1'b0, $urandom);
    drive_item(qpc_pkg::OP_SET,    2'b00, 1'b0, 32'h8000_0000);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b00, 1'b0, $urandom);
    drive_item(qpc_pkg::OP_ARM,    2'b01, 1'b1, -32'sd1234);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b10, 1'b1, $urandom);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b00, 1'b1, $urandom);
    drive_item(qpc_pkg::OP_NOP,    2'b11, 1'b1, '1);
    drive_item(qpc_pkg::OP_SET,    2'b00, 1'b0, '1);
    drive_item(qpc_pkg::OP_SET,    2'b00, 1'b0, '0);

    // small modulus: rejected values, wrap at both ends, preset load
    load_modulus(plan[0]);
    drive_item(qpc_pkg::OP_SET,    2'b00, 1'b0, '1);
    drive_item(qpc_pkg::OP_SET,    2'b00, 1'b0, 32'd5);
    drive_item(qpc_pkg::OP_SET,    2'b00, 1'b0, 32'd4);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b10, 1'b0, $urandom);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b00, 1'b0, $urandom);
    drive_item(qpc_pkg::OP_ARM,    2'b00, 1'b0, 32'd7);
    drive_item(qpc_pkg::OP_ARM,    2'b00, 1'b0, 32'd3);
    drive_item(qpc_pkg::OP_SAMPLE, 2'b00, 1'b1, $urandom);

    // random phases over several modulus settings, the last one without idling
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) idling_on = 1'b0;
      if (p > 0) load_modulus(plan[p]);
      for (i = 0; i < PHASE_ITEMS; i++) random_item(plan[p]);
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/qpc_pkg.sv
hdl/qpc_remainder.sv
hdl/qpc_step.sv
hdl/quadrature_position_counter_core.sv
tb/qpc_position_check.sv
tb/quadrature_position_counter_core_test.sv
